// File: src/fmss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmss_pkg
// Shared types and constants of the first-match substring search block.
// ----------------------------------------------------------------------------
package fmss_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned OFFSET_W       = 32;
  localparam int unsigned CFG_LEN_W      = 6;
  localparam int unsigned PATTERN_WORDS  = 4;
  localparam int unsigned BYTES_PER_WORD = 8;
  localparam int unsigned WORD_W         = BYTES_PER_WORD * BYTE_W;
  localparam int unsigned APB_DATA_W     = 64;
  localparam int unsigned APB_ADDR_W     = 6;
  localparam int unsigned REG_IDX_W      = 3;
  localparam int unsigned REG_IDX_LSB    = 3;

  localparam logic [CFG_LEN_W-1:0] LENGTH_RESET = CFG_LEN_W'(1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD0  = 3'd1,
    REG_PATTERN_WORD1  = 3'd2,
    REG_PATTERN_WORD2  = 3'd3,
    REG_PATTERN_WORD3  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [PATTERN_WORDS-1:0][WORD_W-1:0] words;
    logic [CFG_LEN_W-1:0]                 length;
  } cfg_t;

endpackage

`default_nettype wire

// File: src/fmss_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmss_text_if / fmss_result_if
// Valid/ready channels for text bytes in and search results out.
// ----------------------------------------------------------------------------
interface fmss_text_if;
  logic                           valid;
  logic                           ready;
  logic [fmss_pkg::BYTE_W-1:0]    text_byte;
  logic                           last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface fmss_result_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [fmss_pkg::OFFSET_W-1:0]  match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

// File: src/first_match_substring_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_match_substring_search_top
// Reports the offset of the first occurrence of a configured pattern in a
// byte stream, or not found on the last byte.
// ----------------------------------------------------------------------------
// A result is registered in the back end after its byte has passed through the queue.
// Throughput: one text byte per cycle while the result channel is not stalled, set by
// the prefix-bit update in the back end; a two-entry queue decouples byte compare from that update.
// Reset: search state and the queue clear; pattern length resets to 1 and pattern
// bytes to zero.
module first_match_substring_search_top #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  fmss_text_if.sink                              text_i,
  fmss_result_if.source                          result_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fmss_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [fmss_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [fmss_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  localparam int unsigned LEN_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned ENTRY_W = PATTERN_MAX + LEN_W + 1;

  fmss_pkg::cfg_t      cfg;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0]  push_data, pop_data;

  fmss_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fmss_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .text_i       (text_i),
    .cfg_i        (cfg),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  fmss_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  fmss_back #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// File: src/fmss_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmss_cfg_regs
// APB register file holding the pattern length and the pattern bytes.
// ----------------------------------------------------------------------------
module fmss_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fmss_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [fmss_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [fmss_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output fmss_pkg::cfg_t                         cfg_o
);

  fmss_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [fmss_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[fmss_pkg::REG_IDX_LSB +: fmss_pkg::REG_IDX_W];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        fmss_pkg::REG_PATTERN_LENGTH: cfg_d.length   = pwdata[fmss_pkg::CFG_LEN_W-1:0];
        fmss_pkg::REG_PATTERN_WORD0:  cfg_d.words[0] = pwdata;
        fmss_pkg::REG_PATTERN_WORD1:  cfg_d.words[1] = pwdata;
        fmss_pkg::REG_PATTERN_WORD2:  cfg_d.words[2] = pwdata;
        fmss_pkg::REG_PATTERN_WORD3:  cfg_d.words[3] = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fmss_pkg::REG_PATTERN_LENGTH:
        prdata = fmss_pkg::APB_DATA_W'(cfg_q.length);
      fmss_pkg::REG_PATTERN_WORD0: prdata = cfg_q.words[0];
      fmss_pkg::REG_PATTERN_WORD1: prdata = cfg_q.words[1];
      fmss_pkg::REG_PATTERN_WORD2: prdata = cfg_q.words[2];
      fmss_pkg::REG_PATTERN_WORD3: prdata = cfg_q.words[3];
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.length <= fmss_pkg::LENGTH_RESET;
      cfg_q.words  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/fmss_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmss_front
// Accepts text bytes and compares each byte against every pattern byte.
// ----------------------------------------------------------------------------
module fmss_front #(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned LEN_W       = 5,
  parameter int unsigned ENTRY_W     = PATTERN_MAX + LEN_W + 1
) (
  fmss_text_if.sink                 text_i,
  input  wire fmss_pkg::cfg_t       cfg_i,
  output logic                      push_valid_o,
  input  wire logic                 push_ready_i,
  output logic [ENTRY_W-1:0]        push_data_o
);

  typedef struct packed {
    logic [PATTERN_MAX-1:0] eq;
    logic [LEN_W-1:0]       len_m1;
    logic                   last;
  } entry_t;

  entry_t                          entry;
  logic [fmss_pkg::CFG_LEN_W-1:0]  len_eff;

  // Clamp length into 1..PATTERN_MAX
  always_comb begin
    priority if (cfg_i.length == '0) begin
      len_eff = fmss_pkg::CFG_LEN_W'(1);
    end else if (cfg_i.length > fmss_pkg::CFG_LEN_W'(PATTERN_MAX)) begin
      len_eff = fmss_pkg::CFG_LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = cfg_i.length;
    end
  end

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cmp
    assign entry.eq[k] =
      (cfg_i.words[k / fmss_pkg::BYTES_PER_WORD]
         [(k % fmss_pkg::BYTES_PER_WORD) * fmss_pkg::BYTE_W +: fmss_pkg::BYTE_W]
       == text_i.text_byte) &&
      (fmss_pkg::CFG_LEN_W'(k) < len_eff);
  end

  assign entry.len_m1 = LEN_W'(len_eff - fmss_pkg::CFG_LEN_W'(1));
  assign entry.last   = text_i.last_byte;

  assign push_valid_o = text_i.valid;
  assign text_i.ready = push_ready_i;
  assign push_data_o  = entry;

endmodule

`default_nettype wire

// File: src/fmss_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmss_queue
// Two-entry queue between the compare front and the match back end.
// ----------------------------------------------------------------------------
module fmss_queue #(
  parameter int unsigned ENTRY_W = 38
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_valid_i,
  output logic                      push_ready_o,
  input  wire logic [ENTRY_W-1:0]   push_data_i,
  output logic                      pop_valid_o,
  input  wire logic                 pop_ready_i,
  output logic [ENTRY_W-1:0]        pop_data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = 1;
  localparam int unsigned CNT_W = 2;

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: src/fmss_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmss_back
// Shift-and prefix tracking, offset counting and the result register.
// ----------------------------------------------------------------------------
module fmss_back #(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned LEN_W       = 5,
  parameter int unsigned ENTRY_W     = PATTERN_MAX + LEN_W + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 pop_valid_i,
  output logic                      pop_ready_o,
  input  wire logic [ENTRY_W-1:0]   pop_data_i,
  fmss_result_if.source             result_o
);

  typedef struct packed {
    logic [PATTERN_MAX-1:0] eq;
    logic [LEN_W-1:0]       len_m1;
    logic                   last;
  } entry_t;

  localparam logic [fmss_pkg::OFFSET_W-1:0] OFFSET_MAX = '1;

  entry_t                          entry;
  logic [PATTERN_MAX-1:0]          hits_q, hits_d, hits_new;
  logic [fmss_pkg::OFFSET_W-1:0]   offset_q, offset_d;
  logic                            reported_q, reported_d;
  logic                            valid_q, valid_d;
  logic                            found_q, found_d;
  logic [fmss_pkg::OFFSET_W-1:0]   match_off_q, match_off_d;
  logic [fmss_pkg::OFFSET_W-1:0]   back_dist;
  logic                            pop, hit;

  assign entry       = entry_t'(pop_data_i);
  assign pop_ready_o = ~valid_q | result_o.ready;
  assign pop         = pop_valid_i & pop_ready_o;
  assign hits_new    = PATTERN_MAX'({hits_q, 1'b1}) & entry.eq;
  assign hit         = hits_new[entry.len_m1];
  assign back_dist   = fmss_pkg::OFFSET_W'(entry.len_m1);

  always_comb begin
    hits_d      = hits_q;
    offset_d    = offset_q;
    reported_d  = reported_q;
    valid_d     = valid_q & ~result_o.ready;
    found_d     = found_q;
    match_off_d = match_off_q;
    if (pop) begin
      if (!reported_q) begin
        hits_d = hits_new;
        if (hit) begin
          reported_d  = 1'b1;
          valid_d     = 1'b1;
          found_d     = 1'b1;
          // Clamp the start at zero if the offset is below the back distance
          match_off_d = (offset_q >= back_dist) ? offset_q - back_dist : '0;
        end
      end
      if (offset_q != OFFSET_MAX) begin
        offset_d = offset_q + fmss_pkg::OFFSET_W'(1);
      end
      if (entry.last) begin
        if (!reported_q && !hit) begin
          valid_d     = 1'b1;
          found_d     = 1'b0;
          match_off_d = '0;
        end
        hits_d     = '0;
        offset_d   = '0;
        reported_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q     <= '0;
      offset_q   <= '0;
      reported_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      hits_q     <= hits_d;
      offset_q   <= offset_d;
      reported_q <= reported_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q     <= found_d;
    match_off_q <= match_off_d;
  end

  assign result_o.valid        = valid_q;
  assign result_o.found        = found_q;
  assign result_o.match_offset = match_off_q;

endmodule

`default_nettype wire
